FILE: sv/mi3_pkg.sv
// Package for the 3x3 matrix inverse: widths, cofactor index table and
// the record types handed along the divider chain. No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int IN_W       = 16;   // Q7.8 entry
    localparam int NUM_ENT    = 9;    // entries per matrix
    localparam int PROD_W     = 32;   // 16x16 product
    localparam int ADJ_W      = 33;   // adjugate entry, Q16.16 raw
    localparam int MAG_W      = 32;   // |adjugate| fits 32 bits unsigned
    localparam int DPROD_W    = 48;   // entry times adjugate entry
    localparam int DET_W      = 49;   // determinant, Q24.24 raw
    localparam int REM_W      = 49;   // partial remainder, below |det|
    localparam int QUO_W      = 33;   // quotient magnitude bits
    localparam int INV_W      = 32;   // Q15.16 result
    localparam int FRAC_SHIFT = 24;   // numerator is adj * 2^24
    localparam int PRE_SHIFT  = QUO_W - FRAC_SHIFT;   // high numerator bits
    localparam int NUM_CELLS  = QUO_W;                // one quotient bit per cell
    localparam int S_TDATA_W  = ((IN_W * NUM_ENT + 7) / 8) * 8;
    localparam int M_DATA_RAW = INV_W * NUM_ENT + DET_W;
    localparam int M_TDATA_W  = ((M_DATA_RAW + 7) / 8) * 8;

    // adj[i] = a[t0]*a[t1] - a[t2]*a[t3] (transposed cofactors)
    localparam int ADJ_IDX [0:8][0:3] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    // one inverse entry in flight through the divider chain
    typedef struct packed {
        logic [REM_W-1:0] rem;   // partial remainder
        logic [MAG_W-1:0] num;   // numerator bits still to bring down, MSB first
        logic [QUO_W-1:0] quo;   // quotient bits so far
        logic             ovf;   // quotient beyond QUO_W bits
        logic             neg;   // result sign
    } lane_t;

    // one matrix in flight through the divider chain
    typedef struct packed {
        lane_t [NUM_ENT-1:0]     lane;
        logic [DET_W-1:0]        dmag;      // |det|
        logic signed [DET_W-1:0] det;
        logic                    singular;
    } div_word_t;

endpackage

FILE: sv/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse by adjugate over determinant.
// Depends on mi3_pkg, mi3_cofactor and mi3_div_cell.
//
//  channel | dir | tdata                          | tuser
//  s_      | in  | m00..m22, 16b each, 144b       | -
//  m_      | out | inv00..inv22 32b, det 49b, 344b| singular
//
// One matrix per cycle sustained while the output is not stalled. The path is six
// front-end stages, 33 divider cells (one quotient bit each), one output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output parks one word in a skid register; the whole pipeline
// then holds and s_tready drops until the skid register drains.
`timescale 1ns / 1ps

module matrix_inverse_3x3 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  logic [mi3_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
    // determinant, zero pad, from bit 0 up
    output logic [mi3_pkg::M_TDATA_W-1:0] m_tdata,
    // singular
    output logic                          m_tuser
);

    localparam int NC = mi3_pkg::NUM_CELLS;

    logic                 en;
    logic                 chain_valid [NC+1];
    mi3_pkg::div_word_t   chain_word  [NC+1];

    logic [mi3_pkg::M_TDATA_W-1:0] res_data;
    logic [mi3_pkg::INV_W-1:0]     inv [mi3_pkg::NUM_ENT];
    logic                          push;

    logic                          out_valid_reg;
    logic [mi3_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                          out_user_reg;
    logic                          skid_valid_reg;
    logic [mi3_pkg::M_TDATA_W-1:0] skid_data_reg;
    logic                          skid_user_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // front end
    mi3_cofactor u_cofactor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (chain_valid[0]),
        .out_word  (chain_word[0])
    );

    // divider chain
    for (genvar k = 0; k < NC; k++) begin : g_cell
        mi3_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[k]),
            .in_word   (chain_word[k]),
            .out_valid (chain_valid[k+1]),
            .out_word  (chain_word[k+1])
        );
    end

    // sign, saturation and singular forcing
    always_comb begin
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
            if (chain_word[NC].singular) begin
                inv[i] = '0;
            end else if (chain_word[NC].lane[i].neg) begin
                if (chain_word[NC].lane[i].ovf || chain_word[NC].lane[i].quo[32]
                    || (chain_word[NC].lane[i].quo[31]
                        && (chain_word[NC].lane[i].quo[30:0] != '0))) begin
                    inv[i] = {1'b1, {(mi3_pkg::INV_W-1){1'b0}}};
                end else begin
                    inv[i] = mi3_pkg::INV_W'(-chain_word[NC].lane[i].quo[31:0]);
                end
            end else begin
                if (chain_word[NC].lane[i].ovf || chain_word[NC].lane[i].quo[32]
                    || chain_word[NC].lane[i].quo[31]) begin
                    inv[i] = {1'b0, {(mi3_pkg::INV_W-1){1'b1}}};
                end else begin
                    inv[i] = chain_word[NC].lane[i].quo[31:0];
                end
            end
        end
        res_data = '0;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
            res_data[i*mi3_pkg::INV_W +: mi3_pkg::INV_W] = inv[i];
        end
        res_data[mi3_pkg::NUM_ENT*mi3_pkg::INV_W +: mi3_pkg::DET_W] = chain_word[NC].det;
    end

    assign push = en && chain_valid[NC];

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    out_user_reg   <= skid_user_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                    out_data_reg  <= res_data;
                    out_user_reg  <= chain_word[NC].singular;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
                skid_user_reg  <= chain_word[NC].singular;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // skid register only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without output stall");

    // singular results carry all-zero inverse and determinant
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular result with nonzero data");

    a_nonsingular_det: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser)
        |-> (m_tdata[mi3_pkg::NUM_ENT*mi3_pkg::INV_W +: mi3_pkg::DET_W] != '0))
        else $error("zero determinant not flagged singular");

endmodule

FILE: sv/mi3_cofactor.sv
// Front end of the 3x3 inverse: adjugate, determinant, signs, magnitudes
// and divider seed, six register stages. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_cofactor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mi3_pkg::S_TDATA_W-1:0] in_data,
    output logic                          out_valid,
    output mi3_pkg::div_word_t            out_word
);

    localparam int N = mi3_pkg::NUM_ENT;

    logic signed [mi3_pkg::IN_W-1:0]    a [N];
    logic [5:0]                         vld_reg;

    logic signed [mi3_pkg::PROD_W-1:0]  pa_reg [N];
    logic signed [mi3_pkg::PROD_W-1:0]  pb_reg [N];
    logic signed [mi3_pkg::IN_W-1:0]    r1_reg [3];
    logic signed [mi3_pkg::ADJ_W-1:0]   adj2_reg [N];
    logic signed [mi3_pkg::IN_W-1:0]    r2_reg [3];
    logic signed [mi3_pkg::ADJ_W-1:0]   adj3_reg [N];
    logic signed [mi3_pkg::DPROD_W-1:0] dp_reg [3];
    logic signed [mi3_pkg::ADJ_W-1:0]   adj4_reg [N];
    logic signed [mi3_pkg::DET_W-1:0]   det4_reg;
    logic [mi3_pkg::MAG_W-1:0]          mag5_reg [N];
    logic [N-1:0]                       neg5_reg;
    logic signed [mi3_pkg::DET_W-1:0]   det5_reg;
    logic [mi3_pkg::DET_W-1:0]          dmag5_reg;
    mi3_pkg::div_word_t                 word_reg;

    // unpack entries, m00 in the lowest bits
    always_comb begin
        for (int i = 0; i < N; i++) begin
            a[i] = in_data[i*mi3_pkg::IN_W +: mi3_pkg::IN_W];
        end
    end

    // stage valid shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: 2x2 minor products
            for (int i = 0; i < N; i++) begin
                pa_reg[i] <= a[mi3_pkg::ADJ_IDX[i][0]] * a[mi3_pkg::ADJ_IDX[i][1]];
                pb_reg[i] <= a[mi3_pkg::ADJ_IDX[i][2]] * a[mi3_pkg::ADJ_IDX[i][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r1_reg[j] <= a[j];
            end
            // stage 2: adjugate entries
            for (int i = 0; i < N; i++) begin
                adj2_reg[i] <= mi3_pkg::ADJ_W'(pa_reg[i]) - mi3_pkg::ADJ_W'(pb_reg[i]);
            end
            r2_reg <= r1_reg;
            // stage 3: first-row expansion terms, operands sign-extended first
            dp_reg[0] <= mi3_pkg::DPROD_W'(r2_reg[0]) * mi3_pkg::DPROD_W'(adj2_reg[0]);
            dp_reg[1] <= mi3_pkg::DPROD_W'(r2_reg[1]) * mi3_pkg::DPROD_W'(adj2_reg[3]);
            dp_reg[2] <= mi3_pkg::DPROD_W'(r2_reg[2]) * mi3_pkg::DPROD_W'(adj2_reg[6]);
            adj3_reg  <= adj2_reg;
            // stage 4: determinant
            det4_reg <= mi3_pkg::DET_W'(dp_reg[0]) + mi3_pkg::DET_W'(dp_reg[1])
                        + mi3_pkg::DET_W'(dp_reg[2]);
            adj4_reg <= adj3_reg;
            // stage 5: magnitudes and result signs
            det5_reg  <= det4_reg;
            dmag5_reg <= det4_reg[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det4_reg)
                                                    : mi3_pkg::DET_W'(det4_reg);
            for (int i = 0; i < N; i++) begin
                mag5_reg[i] <= adj4_reg[i][mi3_pkg::ADJ_W-1]
                             ? mi3_pkg::MAG_W'(-adj4_reg[i])
                             : mi3_pkg::MAG_W'(adj4_reg[i]);
                neg5_reg[i] <= adj4_reg[i][mi3_pkg::ADJ_W-1] ^ det4_reg[mi3_pkg::DET_W-1];
            end
            // stage 6: divider seed, high numerator bits and overflow check
            for (int i = 0; i < N; i++) begin
                word_reg.lane[i].rem <= mi3_pkg::REM_W'(mag5_reg[i] >> mi3_pkg::PRE_SHIFT);
                word_reg.lane[i].ovf <= mi3_pkg::DET_W'(mag5_reg[i] >> mi3_pkg::PRE_SHIFT)
                                        >= dmag5_reg;
                word_reg.lane[i].num <= mag5_reg[i] << (mi3_pkg::MAG_W - mi3_pkg::PRE_SHIFT);
                word_reg.lane[i].quo <= '0;
                word_reg.lane[i].neg <= neg5_reg[i];
            end
            word_reg.dmag     <= dmag5_reg;
            word_reg.det      <= det5_reg;
            word_reg.singular <= (det5_reg == '0);
        end
    end

    assign out_valid = vld_reg[5];
    assign out_word  = word_reg;

endmodule

FILE: sv/mi3_div_cell.sv
// One cell of the divider chain: brings down one numerator bit and makes
// one quotient bit for all nine entries. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  mi3_pkg::div_word_t in_word,
    output logic               out_valid,
    output mi3_pkg::div_word_t out_word
);

    logic                 valid_reg;
    mi3_pkg::div_word_t   word_reg;
    mi3_pkg::div_word_t   word_next;
    logic [mi3_pkg::REM_W:0] trial [mi3_pkg::NUM_ENT];
    logic [mi3_pkg::NUM_ENT-1:0] ge;

    // restoring step per lane
    always_comb begin
        word_next = in_word;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
            trial[i] = {in_word.lane[i].rem, in_word.lane[i].num[mi3_pkg::MAG_W-1]};
            ge[i]    = trial[i] >= {1'b0, in_word.dmag};
            word_next.lane[i].rem = ge[i]
                ? mi3_pkg::REM_W'(trial[i] - {1'b0, in_word.dmag})
                : mi3_pkg::REM_W'(trial[i]);
            word_next.lane[i].num = in_word.lane[i].num << 1;
            word_next.lane[i].quo = {in_word.lane[i].quo[mi3_pkg::QUO_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: tb/matrix_inverse_3x3_checker.sv
// Checker for the 3x3 matrix inverse: watches both stream channels, predicts
// each result word from the accepted matrix and compares. Depends on mi3_pkg.
`timescale 1ns / 1ps

module matrix_inverse_3x3_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [mi3_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mi3_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            pending
);

    typedef struct {
        logic [mi3_pkg::INV_W-1:0] inv [mi3_pkg::NUM_ENT];
        logic [mi3_pkg::DET_W-1:0] det;
        logic                      singular;
    } inverse_t;

    inverse_t inverse_q [$];

    // adjugate over determinant, quotient truncated toward zero, saturated
    function automatic inverse_t invert_matrix(logic [mi3_pkg::S_TDATA_W-1:0] word);
        longint a [mi3_pkg::NUM_ENT];
        longint adj [mi3_pkg::NUM_ENT];
        longint det;
        longint q;
        inverse_t r;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
            a[i] = longint'($signed(word[i*mi3_pkg::IN_W +: mi3_pkg::IN_W]));
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        r.singular = (det == 0);
        r.det = r.singular ? '0 : det[mi3_pkg::DET_W-1:0];
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
            if (r.singular) begin
                q = 0;
            end else begin
                // |adj| < 2^33, times 2^24 fits in 64 bits
                q = (adj[i] * (64'sd1 << mi3_pkg::FRAC_SHIFT)) / det;
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
            end
            r.inv[i] = q[mi3_pkg::INV_W-1:0];
        end
        return r;
    endfunction

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        inverse_t exp_r;
        int       errs;
        errs = 0;
        if (aresetn && s_tvalid && s_tready)
            inverse_q.push_back(invert_matrix(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: result word with none expected: %h", $time, m_tdata);
                errs++;
            end else begin
                exp_r = inverse_q.pop_front();
                for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
                    if (m_tdata[i*mi3_pkg::INV_W +: mi3_pkg::INV_W] !== exp_r.inv[i]) begin
                        $display("%0t: inv entry %0d expected %h actual %h", $time, i,
                                 exp_r.inv[i], m_tdata[i*mi3_pkg::INV_W +: mi3_pkg::INV_W]);
                        errs++;
                    end
                if (m_tdata[mi3_pkg::NUM_ENT*mi3_pkg::INV_W +: mi3_pkg::DET_W]
                    !== exp_r.det) begin
                    $display("%0t: determinant expected %h actual %h", $time, exp_r.det,
                             m_tdata[mi3_pkg::NUM_ENT*mi3_pkg::INV_W +: mi3_pkg::DET_W]);
                    errs++;
                end
                if (m_tuser !== exp_r.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             exp_r.singular, m_tuser);
                    errs++;
                end
            end
        end
        if (errs != 0)
            fail_count <= fail_count + errs;
        pending = inverse_q.size();
    end

endmodule

FILE: tb/matrix_inverse_3x3_test.sv
// Testbench top for matrix_inverse_3x3: drives matrices with random gaps and
// back-pressure, gives the verdict. Depends on mi3_pkg and the checker.
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;

    localparam int LATENCY   = 40;
    localparam int WDOG_LIMIT = 20000;

    logic                           aclk = 0;
    logic                           aresetn = 0;
    logic                           s_tvalid = 0;
    logic                           s_tready;
    logic [mi3_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 0;
    logic [mi3_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    int                             fail_count;
    int                             pending;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 0;
    int  idle_cycles = 0;

    always #5 aclk = ~aclk;

    matrix_inverse_3x3 dut (.*);

    matrix_inverse_3x3_checker chk (.*);

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one matrix, hold it until accepted
    task automatic send_matrix(logic [mi3_pkg::S_TDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [mi3_pkg::S_TDATA_W-1:0] pack(int unsigned e [9]);
        logic [mi3_pkg::S_TDATA_W-1:0] w = '0;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
            w[i*mi3_pkg::IN_W +: mi3_pkg::IN_W] = e[i][15:0];
        return w;
    endfunction

    function automatic int unsigned rand_entry();
        case ($urandom_range(3))
            0: return $urandom_range(65535);
            1: return $urandom_range(3) == 0 ? 16'h8000 : 16'h7fff;
            2: return $urandom_range(512) - 256;   // near unity
            default: return $urandom_range(16) - 8; // tiny, big inverses
        endcase
    endfunction

    // random matrix; some made singular by repeated or zero rows, some made diagonal
    function automatic logic [mi3_pkg::S_TDATA_W-1:0] rand_matrix();
        int unsigned e [9];
        for (int i = 0; i < 9; i++) e[i] = rand_entry();
        case ($urandom_range(9))
            0: for (int c = 0; c < 3; c++) e[6+c] = e[c];
            1: for (int c = 0; c < 3; c++) e[3+c] = 0;
            2: for (int c = 0; c < 9; c++) if (c % 3 != c / 3) e[c] = 0;
            default: ;
        endcase
        return pack(e);
    endfunction

    // stop sending and wait until the checker has seen every result
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned e [9];
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: identity, zero, extremes, scaled diagonals, singular rows
        e = '{256, 0, 0, 0, 256, 0, 0, 0, 256};             send_matrix(pack(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(pack(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                   send_matrix(pack(e));
        e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                  send_matrix(pack(e));
        for (int i = 0; i < 9; i++) e[i] = 16'h8000;        send_matrix(pack(e));
        for (int i = 0; i < 9; i++) e[i] = 16'h7fff;        send_matrix(pack(e));
        for (int i = 0; i < 9; i++) e[i] = 16'hffff;        send_matrix(pack(e));
        e = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000}; send_matrix(pack(e));
        e = '{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff}; send_matrix(pack(e));
        e = '{16'h7fff, 16'h8000, 0, 16'h8000, 16'h7fff, 0, 0, 0, 1};
        send_matrix(pack(e));
        e = '{0, 256, 0, 0, 0, 256, 256, 0, 0};             send_matrix(pack(e));
        e = '{512, 256, 0, 256, 512, 256, 0, 256, 512};     send_matrix(pack(e));
        e = '{16'h7fff, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h7fff,
              16'haaaa, 16'h7fff, 16'h8000};                send_matrix(pack(e));
        drain();

        // random phases with differing idle mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 16 : 0;
            for (int n = 0; n < 200; n++) send_matrix(rand_matrix());
            if (ph == 1) drain();
        end

        // long receiver hold-off while matrices keep coming
        fork
            begin
                hold_recv = 1;
                repeat (200) @(posedge aclk);
                hold_recv = 0;
            end
            for (int n = 0; n < 80; n++) send_matrix(rand_matrix());
        join
        drain();
        repeat (LATENCY + 10) @(posedge aclk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: matrix_inverse_3x3.f
sv/mi3_pkg.sv
sv/mi3_cofactor.sv
sv/mi3_div_cell.sv
sv/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_checker.sv
tb/matrix_inverse_3x3_test.sv
